### design/tlc_pkg.sv
// Shared widths, codes and lookup result type for the two-way LRU cache.
package tlc_pkg;

  localparam int ADDR_W          = 7;
  localparam int REG_W           = 3;
  localparam int DATA_W          = 32;
  localparam int MEM_INIT_OFFSET = 5;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  localparam logic WAY0 = 1'b0;
  localparam logic WAY1 = 1'b1;

  typedef struct packed {
    logic hit;
    logic hit_way;
    logic victim_way;
    logic victim_valid;
  } lookup_t;

endpackage

### design/tlc_if.sv
// Valid/ready channel interfaces for the request and result beats.
interface tlc_in_if import tlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [REG_W-1:0]  reg_index;
  logic [ADDR_W-1:0] word_address;

  modport source (output valid, action, reg_index, word_address, input ready);
  modport sink   (input valid, action, reg_index, word_address, output ready);
endinterface

interface tlc_out_if import tlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic              way_used;
  logic              wrote_back;
  logic [DATA_W-1:0] data_value;

  modport source (output valid, hit, way_used, wrote_back, data_value, input ready);
  modport sink   (input valid, hit, way_used, wrote_back, data_value, output ready);
endinterface

### design/tlc_ram.sv
// Single write port, single registered read port RAM with write-to-read forwarding.
module tlc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // forward a same-cycle write so the reader sees the newest word
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

### design/tlc_lookup.sv
// Tag compare of both ways and LRU victim choice for one set.
module tlc_lookup import tlc_pkg::*; #(
  parameter int TAG_W = 4
) (
  input  logic [TAG_W-1:0] tag,
  input  logic [TAG_W-1:0] tag0,
  input  logic [TAG_W-1:0] tag1,
  input  logic             valid0,
  input  logic             valid1,
  input  logic             recent0,
  output lookup_t          lk
);

  logic hit0;
  logic hit1;

  assign hit0 = valid0 && (tag0 == tag);
  assign hit1 = valid1 && (tag1 == tag);

  always_comb begin
    lk.hit     = hit0 || hit1;
    lk.hit_way = hit0 ? WAY0 : WAY1;
    // both empty: take way 0; otherwise evict the way that is not most recent
    if (!valid0 && !valid1) begin
      lk.victim_way = WAY0;
    end else begin
      lk.victim_way = recent0 ? WAY1 : WAY0;
    end
    lk.victim_valid = (lk.victim_way == WAY1) ? valid1 : valid0;
  end

endmodule

### design/two_way_lru_cache_load_store_top.sv
// Top level: two-way set-associative one-word-line cache with load/store execution.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    action, reg_index, word_address
//  out_ch   out  valid / ready    hit, way_used, wrote_back, data_value
//
// One beat per cycle sustained while out_ch is not stalled; a result is valid once its
// request commits. The accept edge launches the registered tag, line and memory reads;
// the commit edge commits all updates and loads the result register. Same-set
// back-to-back requests see fresh data through write forwarding in the RAMs.
// After reset a clearing pass writes address plus five into every memory word, with
// in_ch.ready held low.
// A stalled result register holds the request in the commit stage and blocks acceptance.
module two_way_lru_cache_load_store_top import tlc_pkg::*; #(
  parameter int NUM_LINES = 16,
  parameter int MEM_WORDS = 128,
  parameter int NUM_REGS  = 8
) (
  input logic       clk,
  input logic       rst_n,
  tlc_in_if.sink    in_ch,
  tlc_out_if.source out_ch
);

  localparam int NUM_SETS  = NUM_LINES / 2;
  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int TAG_MAX   = (2 ** ADDR_W - 1) / NUM_SETS;
  localparam int TAG_W     = (TAG_MAX < 1) ? 1 : $clog2(TAG_MAX + 1);
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int RIDX_W    = $clog2(NUM_REGS);
  localparam int AXW       = ADDR_W + 1;
  localparam int CMP_W     = AXW + MEM_AW;
  localparam int QSH       = 2 * ADDR_W;
  localparam int SET_RECIP = (2 ** QSH) / NUM_SETS + 1;
  localparam int PROD_W    = ADDR_W + QSH + 1;
  localparam int RED_STEPS = 3;

  // Reduce a narrow value below n; inputs always stay below four times n.
  function automatic logic [AXW-1:0] mod_reduce(input logic [AXW-1:0] x,
                                                input logic [CMP_W-1:0] n);
    logic [CMP_W-1:0] r;
    r = CMP_W'(x);
    for (int i = 0; i < RED_STEPS; i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r[AXW-1:0];
  endfunction

  // ---------------- handshake and clearing pass ----------------
  logic              clearing_r;
  logic [MEM_AW-1:0] clr_idx_r;
  logic              b_valid_r;
  logic              out_valid_r;
  logic              commit;
  logic              in_ready;
  logic              in_fire;

  assign commit      = b_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready    = !clearing_r && (!b_valid_r || commit);
  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      // advance one word per cycle, drop the flag after the last word
      if (clr_idx_r == MEM_AW'(MEM_WORDS - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // ---------------- request decode (accept side) ----------------
  // Quotient by the set count through a reciprocal, exact over the whole address range.
  logic [PROD_W-1:0] a_prod;
  logic [ADDR_W-1:0] a_quot;
  logic [AXW-1:0]    a_rem;
  logic [SET_W-1:0]  a_set;
  logic [TAG_W-1:0]  a_tag;
  logic [MEM_AW-1:0] a_maddr;
  logic [RIDX_W-1:0] a_reg;

  assign a_prod  = PROD_W'(in_ch.word_address) * PROD_W'(SET_RECIP);
  assign a_quot  = a_prod[QSH +: ADDR_W];
  assign a_rem   = AXW'(in_ch.word_address) - AXW'(AXW'(a_quot) * AXW'(NUM_SETS));
  assign a_set   = SET_W'(a_rem);
  assign a_tag   = TAG_W'(a_quot);
  assign a_maddr = MEM_AW'(mod_reduce(AXW'(in_ch.word_address), CMP_W'(MEM_WORDS)));
  assign a_reg   = RIDX_W'(mod_reduce(AXW'(in_ch.reg_index), CMP_W'(NUM_REGS)));

  // ---------------- commit stage registers ----------------
  logic              b_action_r;
  logic [RIDX_W-1:0] b_reg_r;
  logic [SET_W-1:0]  b_set_r;
  logic [TAG_W-1:0]  b_tag_r;
  logic [MEM_AW-1:0] b_maddr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_fire) begin
      b_valid_r <= 1'b1;
    end else if (commit) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_action_r <= in_ch.action;
      b_reg_r    <= a_reg;
      b_set_r    <= a_set;
      b_tag_r    <= a_tag;
      b_maddr_r  <= a_maddr;
    end
  end

  // ---------------- storage ----------------
  logic              valid0_r  [NUM_SETS];
  logic              valid1_r  [NUM_SETS];
  logic              recent0_r [NUM_SETS];
  logic [DATA_W-1:0] regfile_r [NUM_REGS];

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_q;
  logic              tag0_we;
  logic              tag1_we;
  logic [TAG_W-1:0]  tag0_q;
  logic [TAG_W-1:0]  tag1_q;
  logic              dat0_we;
  logic              dat1_we;
  logic [DATA_W-1:0] dat_wdata;
  logic [DATA_W-1:0] dat0_q;
  logic [DATA_W-1:0] dat1_q;

  tlc_ram #(.DEPTH(MEM_WORDS), .WIDTH(DATA_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(in_fire), .raddr(a_maddr), .rdata(mem_q)
  );

  tlc_ram #(.DEPTH(NUM_SETS), .WIDTH(TAG_W)) u_tag0 (
    .clk(clk), .we(tag0_we), .waddr(b_set_r), .wdata(b_tag_r),
    .re(in_fire), .raddr(a_set), .rdata(tag0_q)
  );

  tlc_ram #(.DEPTH(NUM_SETS), .WIDTH(TAG_W)) u_tag1 (
    .clk(clk), .we(tag1_we), .waddr(b_set_r), .wdata(b_tag_r),
    .re(in_fire), .raddr(a_set), .rdata(tag1_q)
  );

  tlc_ram #(.DEPTH(NUM_SETS), .WIDTH(DATA_W)) u_dat0 (
    .clk(clk), .we(dat0_we), .waddr(b_set_r), .wdata(dat_wdata),
    .re(in_fire), .raddr(a_set), .rdata(dat0_q)
  );

  tlc_ram #(.DEPTH(NUM_SETS), .WIDTH(DATA_W)) u_dat1 (
    .clk(clk), .we(dat1_we), .waddr(b_set_r), .wdata(dat_wdata),
    .re(in_fire), .raddr(a_set), .rdata(dat1_q)
  );

  // ---------------- lookup and decision ----------------
  lookup_t lk;

  tlc_lookup #(.TAG_W(TAG_W)) u_lookup (
    .tag(b_tag_r), .tag0(tag0_q), .tag1(tag1_q),
    .valid0(valid0_r[b_set_r]), .valid1(valid1_r[b_set_r]),
    .recent0(recent0_r[b_set_r]), .lk(lk)
  );

  logic              is_store;
  logic              load_miss;
  logic              store_miss;
  logic              do_wb;
  logic              way_nxt;
  logic [DATA_W-1:0] reg_val;
  logic [DATA_W-1:0] victim_data;
  logic [TAG_W-1:0]  victim_tag;
  logic [AXW-1:0]    victim_addr;
  logic [MEM_AW-1:0] wb_addr;
  logic [DATA_W-1:0] fill_data;
  logic [DATA_W-1:0] value_nxt;

  assign is_store    = (b_action_r == ACT_STORE);
  assign load_miss   = !is_store && !lk.hit;
  assign store_miss  = is_store && !lk.hit;
  assign do_wb       = load_miss && lk.victim_valid;
  assign reg_val     = regfile_r[b_reg_r];
  assign victim_data = (lk.victim_way == WAY1) ? dat1_q : dat0_q;
  assign victim_tag  = (lk.victim_way == WAY1) ? tag1_q : tag0_q;
  assign victim_addr = AXW'(AXW'(victim_tag) * AXW'(NUM_SETS)) + AXW'(b_set_r);
  assign wb_addr     = MEM_AW'(mod_reduce(victim_addr, CMP_W'(MEM_WORDS)));
  // the fill reads memory after the writeback; take the evicted word if they alias
  assign fill_data   = (do_wb && (wb_addr == b_maddr_r)) ? victim_data : mem_q;

  always_comb begin
    if (lk.hit) begin
      way_nxt = lk.hit_way;
    end else if (is_store) begin
      way_nxt = WAY0;
    end else begin
      way_nxt = lk.victim_way;
    end

    if (is_store) begin
      value_nxt = reg_val;
    end else if (lk.hit) begin
      value_nxt = (lk.hit_way == WAY1) ? dat1_q : dat0_q;
    end else begin
      value_nxt = fill_data;
    end
  end

  // line data: store hit writes the hit way, load miss fills the victim way
  assign dat_wdata = is_store ? reg_val : fill_data;
  assign dat0_we   = commit && (lk.hit ? is_store : !is_store) && (way_nxt == WAY0);
  assign dat1_we   = commit && (lk.hit ? is_store : !is_store) && (way_nxt == WAY1);
  assign tag0_we   = commit && load_miss && (lk.victim_way == WAY0);
  assign tag1_we   = commit && load_miss && (lk.victim_way == WAY1);

  // memory port: clearing pass, then store miss or victim writeback
  always_comb begin
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = DATA_W'(clr_idx_r) + DATA_W'(MEM_INIT_OFFSET);
    end else if (store_miss) begin
      mem_we    = commit;
      mem_waddr = b_maddr_r;
      mem_wdata = reg_val;
    end else begin
      mem_we    = commit && do_wb;
      mem_waddr = wb_addr;
      mem_wdata = victim_data;
    end
  end

  // valid, recency and register file updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid0_r[s]  <= 1'b0;
        valid1_r[s]  <= 1'b0;
        recent0_r[s] <= 1'b0;
      end
      for (int r = 0; r < NUM_REGS; r++) begin
        regfile_r[r] <= '0;
      end
    end else if (commit) begin
      if (!store_miss) begin
        recent0_r[b_set_r] <= (way_nxt == WAY0);
      end
      if (load_miss) begin
        if (lk.victim_way == WAY1) begin
          valid1_r[b_set_r] <= 1'b1;
        end else begin
          valid0_r[b_set_r] <= 1'b1;
        end
      end
      if (!is_store) begin
        regfile_r[b_reg_r] <= value_nxt;
      end
    end
  end

  // ---------------- result register ----------------
  logic              out_hit_r;
  logic              out_way_r;
  logic              out_wb_r;
  logic [DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r  <= lk.hit;
      out_way_r  <= way_nxt;
      out_wb_r   <= do_wb;
      out_data_r <= value_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.way_used   = out_way_r;
  assign out_ch.wrote_back = out_wb_r;
  assign out_ch.data_value = out_data_r;

  // ---------------- assertions ----------------
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clearing_r |-> !in_ch.ready
  ) else $error("request accepted during memory clearing pass");

  a_wb_only_on_load_miss: assert property (
    @(posedge clk) disable iff (!rst_n)
      (commit && do_wb) |-> (!lk.hit && (b_action_r == ACT_LOAD) && !clearing_r)
  ) else $error("writeback outside a load miss");

  a_stalled_request_holds: assert property (
    @(posedge clk) disable iff (!rst_n)
      (b_valid_r && !commit) |=> (b_valid_r && $stable(b_set_r) && $stable(b_tag_r))
  ) else $error("stalled request left the commit stage");

endmodule
